@@ hw/rtl/wti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wti_pkg
// Shared constants, types and codes of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wti_pkg;

  localparam int TABLE_BITS  = 9;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_BITS  = TABLE_BITS + FRAC_BITS;
  localparam int GAIN_FRAC   = 12;

  localparam int STEP_BITS  = 25;
  localparam int SCALE_BITS = 16;
  localparam int GAIN_BITS  = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = STEP_BITS;

  localparam int IN_FIELD_BITS = SAMPLE_BITS + TABLE_BITS + SAMPLE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int MIX_BITS   = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int MUL_A_BITS = MIX_BITS;
  localparam int MUL_B_MAG  = (FRAC_BITS > GAIN_BITS) ? FRAC_BITS :
                              ((GAIN_BITS > SCALE_BITS) ? GAIN_BITS : SCALE_BITS);
  localparam int MUL_B_BITS = MUL_B_MAG + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int OUT_SHIFT  = FRAC_BITS + GAIN_FRAC;

  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = STEP_BITS'(761);
  localparam logic [SCALE_BITS-1:0] MOD_SCALE_RESET  = SCALE_BITS'(761);
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET       = GAIN_BITS'(4096);

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOD_SCALE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_LINEAR = 2'd2;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_READ,
    ST_FRAC,
    ST_MIX,
    ST_GAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_MOD,
    MUL_FRAC,
    MUL_GAIN
  } mul_sel_t;

  typedef struct packed {
    logic     mem_we;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     phase_en;
    logic     rd_en;
    logic     mix_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/wti_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wti_ctrl
// Sequencer of the oscillator: accepts beats and steps the datapath.
// ----------------------------------------------------------------------------
module wti_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tuser,
  input  wti_pkg::status_t status,
  output wti_pkg::cmd_t    cmd
);

  wti_pkg::state_t state;
  wti_pkg::state_t state_next;
  logic            accept;

  assign s_tready = (state == wti_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wti_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wti_pkg::ST_IDLE: begin
        if (accept && (s_tuser == wti_pkg::ACT_TICK)) begin
          state_next = wti_pkg::ST_PHASE;
        end
      end
      wti_pkg::ST_PHASE: state_next = wti_pkg::ST_READ;
      wti_pkg::ST_READ:  state_next = wti_pkg::ST_FRAC;
      wti_pkg::ST_FRAC:  state_next = wti_pkg::ST_MIX;
      wti_pkg::ST_MIX:   state_next = wti_pkg::ST_GAIN;
      wti_pkg::ST_GAIN:  state_next = wti_pkg::ST_DONE;
      wti_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          state_next = wti_pkg::ST_IDLE;
        end
      end
      default: state_next = wti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = wti_pkg::MUL_MOD;
    unique case (state)
      wti_pkg::ST_IDLE: begin
        cmd.mem_we  = accept && (s_tuser == wti_pkg::ACT_WRITE);
        cmd.mul_en  = accept && (s_tuser == wti_pkg::ACT_TICK);
        cmd.mul_sel = wti_pkg::MUL_MOD;
      end
      wti_pkg::ST_PHASE: cmd.phase_en = 1'b1;
      wti_pkg::ST_READ:  cmd.rd_en = 1'b1;
      wti_pkg::ST_FRAC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wti_pkg::MUL_FRAC;
      end
      wti_pkg::ST_MIX: cmd.mix_en = 1'b1;
      wti_pkg::ST_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wti_pkg::MUL_GAIN;
      end
      wti_pkg::ST_DONE: cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/wti_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wti_datapath
// Registers, waveform memory, phase accumulator, shared multiplier and
// output stage of the oscillator.
// ----------------------------------------------------------------------------
module wti_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [wti_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                cfg_valid,
  input  logic [wti_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wti_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wti_pkg::cmd_t                       cmd,
  output wti_pkg::status_t                    status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wti_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  localparam int SB = wti_pkg::SAMPLE_BITS;
  localparam int TB = wti_pkg::TABLE_BITS;
  localparam int FB = wti_pkg::FRAC_BITS;
  localparam int PB = wti_pkg::PHASE_BITS;
  localparam int RB = wti_pkg::PROD_BITS + 1;
  localparam logic signed [RB-1:0] ROUND_HALF =
    RB'(64'sd1 <<< (wti_pkg::OUT_SHIFT - 1));
  localparam logic signed [RB-1:0] SAT_HI = RB'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [RB-1:0] SAT_LO = -SAT_HI - RB'(1);

  logic [wti_pkg::STEP_BITS-1:0]  phase_step;
  logic [wti_pkg::SCALE_BITS-1:0] mod_scale;
  logic [wti_pkg::GAIN_BITS-1:0]  gain_linear;

  logic        [PB-1:0]                     phase;
  logic signed [SB-1:0]                     wave_mem [2**TB];
  logic signed [SB-1:0]                     rd_a;
  logic signed [SB-1:0]                     rd_b;
  logic signed [wti_pkg::MIX_BITS-1:0]      mix;
  logic signed [wti_pkg::PROD_BITS-1:0]     prod;
  logic signed [wti_pkg::MUL_A_BITS-1:0]    op_a;
  logic signed [wti_pkg::MUL_B_BITS-1:0]    op_b;
  logic signed [SB:0]                       diff;
  logic signed [SB-1:0]                     mod_in;
  logic        [TB-1:0]                     wr_addr;
  logic signed [SB-1:0]                     wr_value;
  logic        [TB-1:0]                     rd_addr_a;
  logic        [TB-1:0]                     rd_addr_b;
  logic signed [RB-1:0]                     rounded;
  logic signed [RB-1:0]                     scaled;
  logic signed [SB-1:0]                     sat;
  logic                                     m_tvalid_next;

  assign mod_in   = s_tdata[SB-1:0];
  assign wr_addr  = s_tdata[SB+TB-1:SB];
  assign wr_value = s_tdata[SB+TB+SB-1:SB+TB];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= wti_pkg::PHASE_STEP_RESET;
      mod_scale   <= wti_pkg::MOD_SCALE_RESET;
      gain_linear <= wti_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wti_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data[wti_pkg::STEP_BITS-1:0];
        wti_pkg::REG_MOD_SCALE:   mod_scale   <= cfg_data[wti_pkg::SCALE_BITS-1:0];
        wti_pkg::REG_GAIN_LINEAR: gain_linear <= cfg_data[wti_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign rd_addr_a = phase[PB-1:FB];
  assign rd_addr_b = rd_addr_a + TB'(1);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      wave_mem[wr_addr] <= wr_value;
    end
    if (cmd.rd_en) begin
      rd_a <= wave_mem[rd_addr_a];
      rd_b <= wave_mem[rd_addr_b];
    end
  end

  assign diff = (SB + 1)'(rd_b) - (SB + 1)'(rd_a);

  always_comb begin
    case (cmd.mul_sel)
      wti_pkg::MUL_FRAC: begin
        op_a = wti_pkg::MUL_A_BITS'(diff);
        op_b = wti_pkg::MUL_B_BITS'(phase[FB-1:0]);
      end
      wti_pkg::MUL_GAIN: begin
        op_a = mix;
        op_b = wti_pkg::MUL_B_BITS'(gain_linear);
      end
      default: begin
        op_a = wti_pkg::MUL_A_BITS'(mod_in);
        op_b = wti_pkg::MUL_B_BITS'(mod_scale);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.mix_en) begin
      mix <= (wti_pkg::MIX_BITS'(rd_a) <<< FB) + wti_pkg::MIX_BITS'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.phase_en) begin
      phase <= phase + PB'(phase_step) + prod[PB-1:0];
    end
  end

  assign rounded = RB'(prod) + ROUND_HALF;
  assign scaled  = rounded >>> wti_pkg::OUT_SHIFT;

  always_comb begin
    if (scaled > SAT_HI) begin
      sat = SB'(SAT_HI);
    end else if (scaled < SAT_LO) begin
      sat = SB'(SAT_LO);
    end else begin
      sat = SB'(scaled);
    end
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
    if (cmd.out_load) begin
      m_tdata <= wti_pkg::OUT_DATA_BITS'(sat);
    end
  end

  assign status.out_busy = m_tvalid && !m_tready;

endmodule

@@ hw/rtl/wavetable_oscillator_interp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp_unit
// Wavetable oscillator with linear interpolation between adjacent entries.
// ----------------------------------------------------------------------------
// A table write beat (tuser set) stores one sample and leaves the input ready
// for the next beat. A tick beat (tuser clear) advances the phase and presents
// one sample on the output. The input is ready again from the cycle in which
// that sample enters the output register. A stalled output beat holds the next
// tick in its last step until the beat leaves. Each tick runs in sequence
// through the single shared multiplier (modulation, fraction blend, gain) and
// the registered two-port table read. Table entries never written read back as
// undefined values.
module wavetable_oscillator_interp_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata: mod_sample[15:0], table_addr[24:16], table_value[40:25], zero pad
  input  logic [wti_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // tuser: action[0]
  input  logic [0:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata: out_sample[15:0]
  output logic [wti_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wti_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wti_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wti_pkg::cmd_t    cmd;
  wti_pkg::status_t status;

  assign cfg_ready = 1'b1;

  wti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  wti_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ hw/rtl/wti_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wti_checker
// Port-level checks of the oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module wti_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [0:0]                         s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [wti_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == wti_pkg::ACT_TICK) |=> !s_tready)
    else $error("input taken while a tick is in progress");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == wti_pkg::ACT_WRITE) |=> s_tready)
    else $error("table write stalled the input");

endmodule

bind wavetable_oscillator_interp_unit wti_checker u_wti_checker (.*);

@@ verif/wti_sample_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wti_sample_checker
// Scoreboard for the wavetable oscillator output stream.
// ----------------------------------------------------------------------------
// Follows the accepted input, output and register beats. It keeps its own copy
// of the table, the phase and the registers, predicts the interpolated sample
// for every tick beat, and compares each output beat with the oldest sample
// still waiting. Mismatches and unexpected output beats are counted.
module wti_sample_checker
  import wti_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,
  input  logic [0:0]                s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [OUT_DATA_BITS-1:0]  m_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam int MOD_LSB   = 0;
  localparam int ADDR_LSB  = SAMPLE_BITS;
  localparam int VALUE_LSB = SAMPLE_BITS + TABLE_BITS;
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic [STEP_BITS-1:0]          step_reg;
  logic [SCALE_BITS-1:0]         scale_reg;
  logic [GAIN_BITS-1:0]          gain_reg;
  logic [PHASE_BITS-1:0]         phase_acc;
  logic signed [SAMPLE_BITS-1:0] wave_mem [2**TABLE_BITS];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  int                            fail_count = 0;

  function automatic logic signed [SAMPLE_BITS-1:0] blend_and_scale(
    input logic [PHASE_BITS-1:0] ph
  );
    logic [TABLE_BITS-1:0] idx_lo;
    logic [TABLE_BITS-1:0] idx_hi;
    longint                frac;
    longint                lo_val;
    longint                hi_val;
    longint                mix;
    longint                scaled;
    idx_lo = ph[PHASE_BITS-1:FRAC_BITS];
    idx_hi = idx_lo + 1'b1;
    frac   = longint'(ph[FRAC_BITS-1:0]);
    lo_val = wave_mem[idx_lo];
    hi_val = wave_mem[idx_hi];
    mix    = lo_val * ((longint'(1) << FRAC_BITS) - frac) + hi_val * frac;
    scaled = (mix * longint'(gain_reg) + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (scaled > SAT_HI) begin
      scaled = SAT_HI;
    end
    if (scaled < SAT_LO) begin
      scaled = SAT_LO;
    end
    return SAMPLE_BITS'(scaled);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] mod_val;
    logic signed [SAMPLE_BITS-1:0] want;
    longint                        delta;
    if (rst) begin
      step_reg  = PHASE_STEP_RESET;
      scale_reg = MOD_SCALE_RESET;
      gain_reg  = GAIN_RESET;
      phase_acc = '0;
      expected_samples.delete();
    end else begin
      // Output first: a beat leaving now can never belong to a tick taken now.
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $error("out_sample: expected none, got %0d", $signed(m_tdata[SAMPLE_BITS-1:0]));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata[SAMPLE_BITS-1:0] !== want) begin
            fail_count++;
            $error("out_sample: expected %0d, got %0d", want,
                   $signed(m_tdata[SAMPLE_BITS-1:0]));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:  step_reg  = cfg_data[STEP_BITS-1:0];
          REG_MOD_SCALE:   scale_reg = cfg_data[SCALE_BITS-1:0];
          REG_GAIN_LINEAR: gain_reg  = cfg_data[GAIN_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == ACT_WRITE) begin
          wave_mem[s_tdata[ADDR_LSB +: TABLE_BITS]] = s_tdata[VALUE_LSB +: SAMPLE_BITS];
        end else begin
          mod_val   = s_tdata[MOD_LSB +: SAMPLE_BITS];
          delta     = longint'(step_reg) + longint'(mod_val) * longint'(scale_reg);
          phase_acc = phase_acc + delta[PHASE_BITS-1:0];
          expected_samples.push_back(blend_and_scale(phase_acc));
        end
      end
    end
    pending <= expected_samples.size();
    errors  <= fail_count;
  end

endmodule

@@ verif/tb_wavetable_oscillator_interp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator_interp_unit
// Stream testbench for the wavetable oscillator with linear interpolation.
// ----------------------------------------------------------------------------
// Loads the whole table, runs directed ticks on the table seam, the register
// extremes and the modulation extremes, then random mixes of ticks and table
// writes under several register settings and idle patterns, including one
// long output hold-off. The scoreboard module predicts and checks the output.
module tb_wavetable_oscillator_interp_unit;
  import wti_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 140;
  localparam int TABLE_LEN     = 2**TABLE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [STEP_BITS-1:0]    STEP_MAX   = STEP_BITS'(16777216);
  localparam logic [STEP_BITS-1:0]    STEP_SEAM  = STEP_BITS'(24'hFFC000);
  localparam logic [GAIN_BITS-1:0]    GAIN_MAX   = '1;
  localparam logic [SCALE_BITS-1:0]   SCALE_MAX  = '1;
  localparam logic [SAMPLE_BITS-1:0]  POS_FULL   = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0]  NEG_FULL   = 16'h8000;

  localparam int SRC_IDLE [4] = '{0, 47, 0, 30};
  localparam int SNK_IDLE [4] = '{0, 0, 47, 30};

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
  logic [0:0]               s_tuser   = '0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;
  int   errors;
  int   pending;

  wavetable_oscillator_interp_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wti_sample_checker u_sample_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin : sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb_wavetable_oscillator_interp_unit: FAIL");
    $finish;
  end

  function automatic logic [GAIN_BITS-1:0] gain_unity();
    return GAIN_BITS'(1 << GAIN_FRAC);
  endfunction

  task automatic send_beat(input logic act, input logic [SAMPLE_BITS-1:0] mod,
                           input logic [TABLE_BITS-1:0] addr,
                           input logic [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= IN_DATA_BITS'({value, addr, mod});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only once every predicted sample is out and the block is idle.
  task automatic settle_and_program(input logic [STEP_BITS-1:0] step,
                                    input logic [SCALE_BITS-1:0] scale,
                                    input logic [GAIN_BITS-1:0] gain);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_PHASE_STEP, CFG_DATA_BITS'(step));
    write_reg(REG_MOD_SCALE, CFG_DATA_BITS'(scale));
    write_reg(REG_GAIN_LINEAR, CFG_DATA_BITS'(gain));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [STEP_BITS-1:0]  step_pick;
    logic [SCALE_BITS-1:0] scale_pick;
    logic [GAIN_BITS-1:0]  gain_pick;
    logic [SAMPLE_BITS-1:0] fill_value;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Load every entry so that no tick ever reads an unwritten one.
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i == 1 || i == TABLE_LEN - 1) begin
        fill_value = POS_FULL;
      end else if (i == 0 || i == TABLE_LEN - 2) begin
        fill_value = NEG_FULL;
      end else begin
        fill_value = SAMPLE_BITS'($urandom);
      end
      send_beat(ACT_WRITE, '0, TABLE_BITS'(i), fill_value);
    end

    // The phase is still zero, so two steps of 255.75 entries land on the seam
    // between the last entry and the first one.
    settle_and_program(STEP_SEAM, '0, gain_unity());
    send_beat(ACT_TICK, POS_FULL, '0, '0);
    send_beat(ACT_TICK, NEG_FULL, '0, '0);

    settle_and_program(PHASE_STEP_RESET, MOD_SCALE_RESET, GAIN_RESET);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_TICK, POS_FULL, '0, '0);
    send_beat(ACT_TICK, NEG_FULL, '0, '0);
    send_beat(ACT_WRITE, POS_FULL, TABLE_BITS'(5), NEG_FULL);
    send_beat(ACT_TICK, '0, '1, POS_FULL);

    settle_and_program(STEP_MAX, SCALE_MAX, GAIN_MAX);
    send_beat(ACT_TICK, POS_FULL, '0, '0);
    send_beat(ACT_TICK, NEG_FULL, '0, '0);
    send_beat(ACT_TICK, '0, '0, '0);
    send_beat(ACT_TICK, POS_FULL, '0, '0);

    settle_and_program('0, '0, '0);
    @(posedge clk);
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_beat(ACT_TICK, POS_FULL, '0, '0);
    send_beat(ACT_TICK, NEG_FULL, '0, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      src_idle_pct  <= SRC_IDLE[seg / 2];
      snk_stall_pct <= SNK_IDLE[seg / 2];
      case ($urandom_range(3))
        0:       step_pick = '0;
        1:       step_pick = STEP_MAX;
        2:       step_pick = STEP_BITS'($urandom_range(1 << 20));
        default: step_pick = STEP_BITS'($urandom_range(STEP_MAX));
      endcase
      case ($urandom_range(3))
        0:       scale_pick = '0;
        1:       scale_pick = SCALE_MAX;
        default: scale_pick = SCALE_BITS'($urandom);
      endcase
      case ($urandom_range(3))
        0:       gain_pick = '0;
        1:       gain_pick = GAIN_MAX;
        2:       gain_pick = GAIN_RESET;
        default: gain_pick = GAIN_BITS'($urandom);
      endcase
      settle_and_program(step_pick, scale_pick, gain_pick);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (seg == 0 && n == 60) begin
          hold_req <= 1'b1;
        end
        if ($urandom_range(99) < 25) begin
          send_beat(ACT_WRITE, SAMPLE_BITS'($urandom), TABLE_BITS'($urandom),
                    SAMPLE_BITS'($urandom));
        end else begin
          send_beat(ACT_TICK, ($urandom_range(1) != 0) ? SAMPLE_BITS'($urandom) : '0,
                    TABLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_wavetable_oscillator_interp_unit: PASS");
    end else begin
      $display("tb_wavetable_oscillator_interp_unit: FAIL");
    end
    $finish;
  end

endmodule
